/* hdl/wxapm_pkg.sv */
// wxapm_pkg: shared types and codes for the w+x alias page map
// payload structs, operation / kind / access codes, decode result and fsm state
// no dependencies
package wxapm_pkg;

    // decoded mapping geometry
    localparam int WORD_W = 15;   // bitmap word index of a decoded frame (20-bit frame / 32)
    localparam int SPAN_W = 7;    // words per mapping minus one, up to 127
    localparam int LIM_W  = 21;   // wide enough to hold the largest map size in words

    // operation codes
    localparam logic [1:0] OP_L1     = 2'd0;
    localparam logic [1:0] OP_L2     = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // descriptor kinds
    localparam logic [2:0] KIND_INVALID = 3'd0;
    localparam logic [2:0] KIND_TABLE   = 3'd1;
    localparam logic [2:0] KIND_SECTION = 3'd2;
    localparam logic [2:0] KIND_SUPER   = 3'd3;
    localparam logic [2:0] KIND_SMALL   = 3'd4;
    localparam logic [2:0] KIND_LARGE   = 3'd5;

    // access classes
    localparam logic [2:0] ACC_NONE    = 3'd0;
    localparam logic [2:0] ACC_USER_RW = 3'd1;
    localparam logic [2:0] ACC_USER_RO = 3'd2;
    localparam logic [2:0] ACC_SUP_RW  = 3'd3;
    localparam logic [2:0] ACC_SUP_RO  = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] descriptor;
        logic [13:0] word_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  access_class;
        logic        executable;
        logic        privileged_never;
        logic        out_of_range;
        logic [31:0] alias_mask;
    } out_word_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [2:0]        access_class;
        logic              executable;
        logic              privileged_never;
        logic              mapping;
        logic              is_read;
        logic              mark_write;
        logic [WORD_W-1:0] start_word;
        logic [SPAN_W-1:0] span_m1;
        logic [31:0]       mask;
    } dec_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_MARK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

/* hdl/wxapm_decode.sv */
// wxapm_decode: combinational decode of one short-format descriptor
// gives kind, access class, xn / pxn and the bitmap word span with its bit mask
// depends on wxapm_pkg
module wxapm_decode
    import wxapm_pkg::*;
(
    input  in_word_t item,
    output dec_t     dec
);

    function automatic logic [2:0] ap_class(input logic ap2, input logic ap1, input logic ap0);
        logic [2:0] cls;
        unique case ({ap2, ap1, ap0})
            3'b011:                   cls = ACC_USER_RW;
            3'b010, 3'b110, 3'b111:   cls = ACC_USER_RO;
            3'b001:                   cls = ACC_SUP_RW;
            3'b101:                   cls = ACC_SUP_RO;
            default:                  cls = ACC_NONE;
        endcase
        return cls;
    endfunction

    logic [31:0] dsc;

    assign dsc = item.descriptor;

    always_comb begin
        dec = '0;
        unique case (item.operation)
            OP_L1: begin
                if (dsc[1:0] == 2'b01) begin
                    dec.kind             = KIND_TABLE;
                    dec.privileged_never = dsc[2];
                end else if (dsc[1]) begin
                    dec.mapping          = 1'b1;
                    dec.access_class     = ap_class(dsc[15], dsc[11], dsc[10]);
                    dec.executable       = ~dsc[4];
                    dec.privileged_never = dsc[0];
                    dec.mask             = '1;
                    if (dsc[18]) begin
                        dec.kind       = KIND_SUPER;
                        dec.start_word = {dsc[31:24], 7'b0000000};
                        dec.span_m1    = 7'd127;
                    end else begin
                        dec.kind       = KIND_SECTION;
                        dec.start_word = {dsc[31:20], 3'b000};
                        dec.span_m1    = 7'd7;
                    end
                end
            end
            OP_L2: begin
                if (dsc[1:0] != 2'b00) begin
                    dec.mapping      = 1'b1;
                    dec.access_class = ap_class(dsc[9], dsc[5], dsc[4]);
                    dec.start_word   = dsc[31:17];
                    if (dsc[1:0] == 2'b01) begin
                        dec.kind       = KIND_LARGE;
                        dec.executable = ~dsc[15];
                        dec.mask       = dsc[16] ? 32'hFFFF_0000 : 32'h0000_FFFF;
                    end else begin
                        dec.kind       = KIND_SMALL;
                        dec.executable = ~dsc[0];
                        dec.mask       = 32'h0000_0001 << dsc[16:12];
                    end
                end
            end
            OP_READ: begin
                dec.is_read = 1'b1;
            end
            default: begin
            end
        endcase
        dec.mark_write = dec.mapping &&
                         (dec.access_class == ACC_USER_RW || dec.access_class == ACC_SUP_RW);
    end

endmodule

/* hdl/wxapm_frame_store.sv */
// wxapm_frame_store: writable and executable frame bitmaps, one word per 32 frames
// one write port and one registered read port, shared address for both bitmaps
// depends on wxapm_pkg
module wxapm_frame_store
    import wxapm_pkg::*;
#(
    parameter int FRAME_WORDS = 16384,
    parameter int AW          = 14
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_exec_reg,
    output logic [31:0]   rd_write_reg,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_exec,
    input  logic [31:0]   wr_write
);

    logic [31:0] exec_bits [FRAME_WORDS];
    logic [31:0] wr_bits   [FRAME_WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            exec_bits[wr_addr] <= wr_exec;
            wr_bits[wr_addr]   <= wr_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_exec_reg  <= exec_bits[rd_addr];
            rd_write_reg <= wr_bits[rd_addr];
        end
    end

endmodule

/* hdl/wx_alias_page_map.sv */
// wx_alias_page_map: short-descriptor permission decoder with w+x alias bitmaps
// top level: sequencer, read-modify-write mark unit, output register
// depends on wxapm_pkg, wxapm_decode, wxapm_frame_store
//
// usage
//   s_ channel carries one word per item: operation, descriptor, word_index
//   m_ channel returns exactly one result word per item, in order
//   operation 0 / 1 decode a level-one / level-two descriptor and mark the
//   frames it maps in the writable and executable bitmaps; operation 2
//   returns the bitmap word of frames that are both writable and executable
// timing
//   one item at a time; s_ready is high only while the sequencer is idle;
//   an item steps through start, then mark and drain if it maps frames,
//   then finish, which loads the output register and returns to idle,
//   where the next word is taken; the shared mark unit handles one bitmap
//   word per cycle (read it, then write it back) through the store's read
//   and write ports
// reset
//   aresetn clears control, then a clearing pass zeroes both bitmaps one
//   word a cycle, during which s_ready stays low
// stall
//   a finished result waits in the output register while m_ready is low;
//   the sequencer holds in its final state until the register frees up
module wx_alias_page_map
    import wxapm_pkg::*;
#(
    parameter int FRAME_WORDS = 16384
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam logic [LIM_W-1:0] FRAME_LIMIT = LIM_W'(FRAME_WORDS);
    localparam logic [AW-1:0]    CLR_LAST    = AW'(FRAME_WORDS - 1);

    state_t            state_reg, state_next;
    in_word_t          item_reg, item_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [SPAN_W-1:0] span_cnt_reg, span_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    out_word_t         out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    dec_t              dec;

    // memory port signals
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [31:0]       rd_exec, rd_write;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [31:0]       wr_exec, wr_write;

    // range checks against the map size
    logic [LIM_W-1:0]  cur_ext, end_ext, widx_ext;
    logic              cur_in_map, map_oor, widx_in_map;
    out_word_t         result;

    wxapm_decode u_decode (
        .item (item_reg),
        .dec  (dec)
    );

    wxapm_frame_store #(
        .FRAME_WORDS (FRAME_WORDS),
        .AW          (AW)
    ) u_store (
        .aclk         (aclk),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_exec_reg  (rd_exec),
        .rd_write_reg (rd_write),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_exec      (wr_exec),
        .wr_write     (wr_write)
    );

    assign cur_ext     = LIM_W'(word_reg);
    assign cur_in_map  = cur_ext < FRAME_LIMIT;
    assign end_ext     = LIM_W'(WORD_W'(dec.start_word + WORD_W'(dec.span_m1)));
    assign map_oor     = end_ext >= FRAME_LIMIT;
    assign widx_ext    = LIM_W'(item_reg.word_index);
    assign widx_in_map = widx_ext < FRAME_LIMIT;

    // shared mark unit: write stage of the read-modify-write, or zeros while clearing
    assign wr_en    = (state_reg == ST_CLEAR) || pend_valid_reg;
    assign wr_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : pend_addr_reg;
    assign wr_exec  = (state_reg == ST_CLEAR) ? 32'h0 :
                      (rd_exec | (dec.executable ? dec.mask : 32'h0));
    assign wr_write = (state_reg == ST_CLEAR) ? 32'h0 :
                      (rd_write | (dec.mark_write ? dec.mask : 32'h0));

    // result word, valid in the finish state
    always_comb begin
        result                  = '0;
        result.kind             = dec.kind;
        result.access_class     = dec.access_class;
        result.executable       = dec.executable;
        result.privileged_never = dec.privileged_never;
        if (dec.mapping) begin
            result.out_of_range = map_oor;
        end else if (dec.is_read) begin
            result.out_of_range = ~widx_in_map;
            result.alias_mask   = widx_in_map ? (rd_exec & rd_write) : 32'h0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        word_reg      <= word_next;
        span_cnt_reg  <= span_cnt_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        clr_cnt_next    = clr_cnt_reg;
        word_next       = word_reg;
        span_cnt_next   = span_cnt_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cur_ext[AW-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                word_next     = dec.start_word;
                span_cnt_next = '0;
                if (dec.mapping) begin
                    state_next = ST_MARK;
                end else begin
                    // alias read: registered data is ready in the finish state
                    rd_en      = dec.is_read && widx_in_map;
                    rd_addr    = widx_ext[AW-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_MARK: begin
                // read this word now, write it back next cycle; skip words past the map
                rd_en           = cur_in_map;
                pend_valid_next = cur_in_map;
                pend_addr_next  = cur_ext[AW-1:0];
                word_next       = word_reg + WORD_W'(1);
                span_cnt_next   = span_cnt_reg + SPAN_W'(1);
                if (span_cnt_reg == dec.span_m1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = result;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // no new word is taken while a bitmap write is still in flight
    a_no_accept_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !pend_valid_reg)
        else $error("item accepted with a bitmap write pending");

    // every pending write lands inside the map
    a_write_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (LIM_W'(pend_addr_reg) < FRAME_LIMIT))
        else $error("bitmap write beyond the map");

    // the clearing pass neither takes items nor shows results
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_ready && !m_valid_reg))
        else $error("channel active during clearing pass");

    // the span counter never runs past the decoded span
    a_span_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |-> (span_cnt_reg <= dec.span_m1))
        else $error("mark span overrun");

endmodule
